/* hdl/julian_day_to_calendar_date_assert.svh */
// assertion macros for the julian day converter
// clocked on clk_i, disabled while rst_ni is low
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define JDCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jdcd assertion failed");
`define JDCD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("jdcd forbidden condition seen");
`else
`define JDCD_ASSERT(lbl, prop)
`define JDCD_ASSERT_NEVER(lbl, expr)
`endif
`endif

/* hdl/jdcd_pkg.sv */
package jdcd_pkg;

  localparam int unsigned DAY_BITS      = 22;
  localparam int unsigned FRACTION_BITS = 32;
  localparam int unsigned VALUE_W       = DAY_BITS + FRACTION_BITS;

  localparam int unsigned YEAR_W        = 14;
  localparam int unsigned MONTH_W       = 4;
  localparam int unsigned DOM_W         = 5;
  localparam int unsigned HOUR_W        = 5;
  localparam int unsigned MINUTE_W      = 6;
  localparam int unsigned SEC_W         = 22;
  localparam int unsigned SEC_FRAC_BITS = 16;

  localparam int unsigned NUM_STAGES    = 10;

  // day number after the half day shift can reach 2^DAY_BITS
  localparam int unsigned Z_W = DAY_BITS + 1;

  localparam logic [VALUE_W:0] HALF_DAY    = (VALUE_W + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [VALUE_W:0] MJD_OFFSET  = ((VALUE_W + 1)'(2400000) << FRACTION_BITS)
                                             + HALF_DAY;
  localparam logic [VALUE_W:0] MJD_DAY_ADD = MJD_OFFSET + HALF_DAY;

  localparam logic [Z_W-1:0] GREGORIAN_START = Z_W'(2299161);

  // alpha = floor((4z - 7468865) / 146097), exact reciprocal multiply
  localparam int unsigned ALPHA_DIV  = 146097;
  localparam int unsigned N1_W       = DAY_BITS + 3;
  localparam logic [N1_W-1:0] ALPHA_BIAS = N1_W'(7468865);
  localparam int unsigned S1         = N1_W + $clog2(ALPHA_DIV);
  localparam int unsigned M1_W       = S1 - $clog2(ALPHA_DIV) + 1;
  localparam logic [M1_W-1:0] M1     = M1_W'(((64'd1 << S1) + 64'(ALPHA_DIV) - 64'd1)
                                             / 64'(ALPHA_DIV));
  localparam int unsigned A_W        = N1_W - $clog2(ALPHA_DIV) + 1;
  localparam int unsigned P1_W       = N1_W + M1_W;
  localparam int unsigned ADJ_W      = A_W + 4;
  localparam int unsigned B_BIAS_JUL  = 1524;
  localparam int unsigned B_BIAS_GREG = 1525;

  // c = floor((20b - 2442) / 7305)
  localparam int unsigned C_DIV      = 7305;
  localparam int unsigned N2_W       = Z_W + 5;
  localparam logic [N2_W-1:0] C_BIAS = N2_W'(2442);
  localparam int unsigned S2         = N2_W + $clog2(C_DIV);
  localparam int unsigned M2_W       = S2 - $clog2(C_DIV) + 1;
  localparam logic [M2_W-1:0] M2     = M2_W'(((64'd1 << S2) + 64'(C_DIV) - 64'd1)
                                             / 64'(C_DIV));
  localparam int unsigned C_W        = N2_W - $clog2(C_DIV) + 1;
  localparam int unsigned P2_W       = N2_W + M2_W;

  // d = floor(1461c / 4), b - d always lies in 123..488
  localparam int unsigned D_MUL      = 1461;
  localparam int unsigned DF_W       = C_W + 11;
  localparam int unsigned BD_W       = 9;

  // e = floor(10000 (b - d) / 306001)
  localparam int unsigned E_MUL      = 10000;
  localparam int unsigned E_DIV      = 306001;
  localparam int unsigned N4_W       = 23;
  localparam int unsigned S4         = N4_W + $clog2(E_DIV);
  localparam int unsigned M4_W       = S4 - $clog2(E_DIV) + 1;
  localparam logic [M4_W-1:0] M4     = M4_W'(((64'd1 << S4) + 64'(E_DIV) - 64'd1)
                                             / 64'(E_DIV));
  localparam int unsigned P4_W       = N4_W + M4_W;
  localparam int unsigned E_W        = 4;

  localparam int unsigned MONTH_WRAP      = 14;
  localparam int unsigned YEAR_BIAS_LATE  = 4716;
  localparam int unsigned YEAR_BIAS_EARLY = 4715;

  localparam int unsigned T1_W = FRACTION_BITS + HOUR_W;
  localparam int unsigned T2_W = FRACTION_BITS + MINUTE_W;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SEC_W-1:0]    seconds;
  } tod_t;

  // floor(306001 e / 10000)
  function automatic logic [BD_W-1:0] month_start_fn(input logic [E_W-1:0] e);
    logic [BD_W-1:0] r;
    case (e)
      4'd0:    r = BD_W'(0);
      4'd1:    r = BD_W'(30);
      4'd2:    r = BD_W'(61);
      4'd3:    r = BD_W'(91);
      4'd4:    r = BD_W'(122);
      4'd5:    r = BD_W'(153);
      4'd6:    r = BD_W'(183);
      4'd7:    r = BD_W'(214);
      4'd8:    r = BD_W'(244);
      4'd9:    r = BD_W'(275);
      4'd10:   r = BD_W'(306);
      4'd11:   r = BD_W'(336);
      4'd12:   r = BD_W'(367);
      4'd13:   r = BD_W'(397);
      4'd14:   r = BD_W'(428);
      default: r = BD_W'(459);
    endcase
    return r;
  endfunction

endpackage

/* hdl/julian_day_to_calendar_date.sv */
// julian day to calendar date, ten register stages
// an accepted request moves through the stages in order, and its result is registered in the output stage
// throughput: one request per cycle; empty stages close up under an output stall,
// so requests keep entering until every stage holds one
// reset: asynchronous, clears the stage valid bits and the mode register (julian day)
`include "julian_day_to_calendar_date_assert.svh"

module julian_day_to_calendar_date (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_write_i,
  input  logic                                  cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [jdcd_pkg::VALUE_W-1:0]          day_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [jdcd_pkg::YEAR_W-1:0]    year_o,
  output logic [jdcd_pkg::MONTH_W-1:0]          month_o,
  output logic [jdcd_pkg::DOM_W-1:0]            day_of_month_o,
  output logic [jdcd_pkg::HOUR_W-1:0]           hour_o,
  output logic [jdcd_pkg::MINUTE_W-1:0]         minute_o,
  output logic [jdcd_pkg::SEC_W-1:0]            seconds_q16_o,
  output logic                                  out_of_range_o
);

  import jdcd_pkg::*;

  logic                  mode_q;
  logic [NUM_STAGES:1]   vld_q;
  logic [NUM_STAGES:1]   stage_en;

  // stage 1
  logic [VALUE_W:0]       sum_chk, sum_day;
  logic                   s1_oor_q;
  logic [Z_W-1:0]         s1_z_q;
  logic [FRACTION_BITS-1:0] s1_f_q;
  // stage 2
  logic [T1_W-1:0]        t1_d;
  logic                   s2_oor_q, s2_greg_q;
  logic [Z_W-1:0]         s2_z_q;
  logic [N1_W-1:0]        s2_n1_q;
  logic [HOUR_W-1:0]      s2_hour_q;
  logic [FRACTION_BITS-1:0] s2_fr_q;
  // stage 3
  logic [T2_W-1:0]        t2_d;
  logic                   s3_oor_q, s3_greg_q;
  logic [Z_W-1:0]         s3_z_q;
  logic [P1_W-1:0]        s3_aprod_q;
  logic [HOUR_W-1:0]      s3_hour_q;
  logic [MINUTE_W-1:0]    s3_min_q;
  logic [FRACTION_BITS-1:0] s3_fr_q;
  // stage 4
  logic [A_W-1:0]         alpha;
  logic [ADJ_W-1:0]       adj;
  logic [Z_W-1:0]         b_d;
  logic [T2_W-1:0]        t3_d;
  logic                   s4_oor_q;
  logic [Z_W-1:0]         s4_b_q;
  tod_t                   s4_tod_q;
  // stage 5
  logic [N2_W-1:0]        n2_d;
  logic                   s5_oor_q;
  logic [Z_W-1:0]         s5_b_q;
  logic [N2_W-1:0]        s5_n2_q;
  tod_t                   s5_tod_q;
  // stage 6
  logic                   s6_oor_q;
  logic [Z_W-1:0]         s6_b_q;
  logic [P2_W-1:0]        s6_cprod_q;
  tod_t                   s6_tod_q;
  // stage 7
  logic [C_W-1:0]         c_d;
  logic [DF_W-1:0]        dfull;
  logic [BD_W-1:0]        bd_d;
  logic                   s7_oor_q;
  logic [C_W-1:0]         s7_c_q;
  logic [BD_W-1:0]        s7_bd_q;
  tod_t                   s7_tod_q;
  // stage 8
  logic                   s8_oor_q;
  logic [C_W-1:0]         s8_c_q;
  logic [BD_W-1:0]        s8_bd_q;
  logic [N4_W-1:0]        s8_n4_q;
  tod_t                   s8_tod_q;
  // stage 9
  logic                   s9_oor_q;
  logic [C_W-1:0]         s9_c_q;
  logic [BD_W-1:0]        s9_bd_q;
  logic [P4_W-1:0]        s9_eprod_q;
  tod_t                   s9_tod_q;
  // output stage
  logic [E_W-1:0]         e;
  logic [MONTH_W-1:0]     month_d;
  logic [BD_W-1:0]        dom_full;
  logic [YEAR_W-1:0]      year_d;
  logic [YEAR_W-1:0]      year_q;
  logic [MONTH_W-1:0]     month_q;
  logic [DOM_W-1:0]       dom_q;
  tod_t                   tod_q;
  logic                   oor_q;

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    stage_en[NUM_STAGES] = !vld_q[NUM_STAGES] || !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k + 1];
    end
  end

  assign in_stall_o = !stage_en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      vld_q  <= '0;
    end else begin
      if (cfg_write_i) begin
        mode_q <= cfg_data_i;
      end
      if (stage_en[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          vld_q[k] <= vld_q[k - 1];
        end
      end
    end
  end

  // offset check and half day shift run side by side
  always_comb begin
    sum_chk = {1'b0, day_value_i} + (mode_q ? MJD_OFFSET : '0);
    sum_day = {1'b0, day_value_i} + (mode_q ? MJD_DAY_ADD : HALF_DAY);
  end

  assign t1_d = T1_W'(s1_f_q) * T1_W'(24);
  assign t2_d = T2_W'(s2_fr_q) * T2_W'(60);
  assign t3_d = T2_W'(s3_fr_q) * T2_W'(60);

  always_comb begin
    alpha = s3_aprod_q[S1 +: A_W];
    adj   = s3_greg_q ? ADJ_W'(B_BIAS_GREG) + ADJ_W'(alpha) - ADJ_W'(alpha >> 2)
                      : ADJ_W'(B_BIAS_JUL);
    b_d   = s3_z_q + Z_W'(adj);
    n2_d  = (N2_W'(s4_b_q) << 4) + (N2_W'(s4_b_q) << 2) - C_BIAS;
  end

  // b - d fits in BD_W bits, so the low bits of both operands are enough
  always_comb begin
    c_d   = s6_cprod_q[S2 +: C_W];
    dfull = DF_W'(c_d) * DF_W'(D_MUL);
    bd_d  = s6_b_q[BD_W-1:0] - dfull[2 +: BD_W];
  end

  always_comb begin
    e        = s9_eprod_q[S4 +: E_W];
    month_d  = (e < E_W'(MONTH_WRAP)) ? MONTH_W'(e - E_W'(1)) : MONTH_W'(e - E_W'(13));
    dom_full = s9_bd_q - month_start_fn(e);
    year_d   = s9_c_q[YEAR_W-1:0]
             - ((month_d > MONTH_W'(2)) ? YEAR_W'(YEAR_BIAS_LATE) : YEAR_W'(YEAR_BIAS_EARLY));
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      s1_oor_q <= sum_chk[VALUE_W];
      s1_z_q   <= sum_day[VALUE_W:FRACTION_BITS];
      s1_f_q   <= sum_day[FRACTION_BITS-1:0];
    end
    if (stage_en[2]) begin
      s2_oor_q  <= s1_oor_q;
      s2_greg_q <= (s1_z_q >= GREGORIAN_START);
      s2_z_q    <= s1_z_q;
      s2_n1_q   <= (N1_W'(s1_z_q) << 2) - ALPHA_BIAS;
      s2_hour_q <= t1_d[FRACTION_BITS +: HOUR_W];
      s2_fr_q   <= t1_d[FRACTION_BITS-1:0];
    end
    if (stage_en[3]) begin
      s3_oor_q   <= s2_oor_q;
      s3_greg_q  <= s2_greg_q;
      s3_z_q     <= s2_z_q;
      s3_aprod_q <= P1_W'(s2_n1_q) * P1_W'(M1);
      s3_hour_q  <= s2_hour_q;
      s3_min_q   <= t2_d[FRACTION_BITS +: MINUTE_W];
      s3_fr_q    <= t2_d[FRACTION_BITS-1:0];
    end
    if (stage_en[4]) begin
      s4_oor_q         <= s3_oor_q;
      s4_b_q           <= b_d;
      s4_tod_q.hour    <= s3_hour_q;
      s4_tod_q.minute  <= s3_min_q;
      s4_tod_q.seconds <= t3_d[(FRACTION_BITS - SEC_FRAC_BITS) +: SEC_W];
    end
    if (stage_en[5]) begin
      s5_oor_q <= s4_oor_q;
      s5_b_q   <= s4_b_q;
      s5_n2_q  <= n2_d;
      s5_tod_q <= s4_tod_q;
    end
    if (stage_en[6]) begin
      s6_oor_q   <= s5_oor_q;
      s6_b_q     <= s5_b_q;
      s6_cprod_q <= P2_W'(s5_n2_q) * P2_W'(M2);
      s6_tod_q   <= s5_tod_q;
    end
    if (stage_en[7]) begin
      s7_oor_q <= s6_oor_q;
      s7_c_q   <= c_d;
      s7_bd_q  <= bd_d;
      s7_tod_q <= s6_tod_q;
    end
    if (stage_en[8]) begin
      s8_oor_q <= s7_oor_q;
      s8_c_q   <= s7_c_q;
      s8_bd_q  <= s7_bd_q;
      s8_n4_q  <= N4_W'(s7_bd_q) * N4_W'(E_MUL);
      s8_tod_q <= s7_tod_q;
    end
    if (stage_en[9]) begin
      s9_oor_q   <= s8_oor_q;
      s9_c_q     <= s8_c_q;
      s9_bd_q    <= s8_bd_q;
      s9_eprod_q <= P4_W'(s8_n4_q) * P4_W'(M4);
      s9_tod_q   <= s8_tod_q;
    end
    if (stage_en[NUM_STAGES]) begin
      // an out of range day gives all-zero date and time
      oor_q   <= s9_oor_q;
      year_q  <= s9_oor_q ? '0 : year_d;
      month_q <= s9_oor_q ? '0 : month_d;
      dom_q   <= s9_oor_q ? '0 : dom_full[DOM_W-1:0];
      tod_q   <= s9_oor_q ? '0 : s9_tod_q;
    end
  end

  assign out_valid_o    = vld_q[NUM_STAGES];
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign hour_o         = tod_q.hour;
  assign minute_o       = tod_q.minute;
  assign seconds_q16_o  = tod_q.seconds;
  assign out_of_range_o = oor_q;

  `JDCD_ASSERT(a_range_zeroes, out_valid_o && out_of_range_o |-> year_o == '0 && month_o == '0 && day_of_month_o == '0 && tod_q == '0)
  `JDCD_ASSERT(a_fields_legal, out_valid_o && !out_of_range_o |-> month_o >= MONTH_W'(1) && month_o <= MONTH_W'(12) && day_of_month_o != '0 && hour_o <= HOUR_W'(23) && minute_o <= MINUTE_W'(59))
  `JDCD_ASSERT_NEVER(a_stall_only_when_full, in_stall_o && !(out_valid_o && out_stall_i))
  `JDCD_ASSERT(a_count_kept, !(in_valid_i && !in_stall_o) && !(out_valid_o && !out_stall_i) |=> $countones(vld_q) == $past($countones(vld_q)))

endmodule
